// ===== hw/rtl/mhq_pkg.sv =====
// Shared types and constants for the mesh height query block.
// Holds the transfer payload structs, the sequencer state enum and the product step table.
// Depends on nothing.
package mhq_pkg;

  localparam int unsigned IndexW  = 10;
  localparam int unsigned CoordW  = 32;
  localparam int unsigned CfgW    = 11;
  localparam int unsigned FaceW   = 3 * IndexW;
  localparam int unsigned VertW   = 3 * CoordW;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned MulW    = DiffW + 1;
  localparam int unsigned ProdW   = 2 * MulW;
  localparam int unsigned CrossW  = 2 * DiffW + 1;
  localparam int unsigned AccW    = 102;
  localparam int unsigned DivW    = AccW - 1;
  localparam int unsigned DivCntW = 7;
  localparam int unsigned StepW   = 4;
  localparam int unsigned HiShift = DiffW;

  typedef enum logic [1:0] {
    FUNC_VERTEX = 2'd0,
    FUNC_FACE   = 2'd1,
    FUNC_QUERY  = 2'd2
  } mhq_func_e;

  typedef struct packed {
    logic [1:0]               func;
    logic [IndexW-1:0]        slot;
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [IndexW-1:0]        corner_a;
    logic [IndexW-1:0]        corner_b;
    logic [IndexW-1:0]        corner_c;
  } mhq_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] altitude;
    logic                     hit;
  } mhq_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FACE_RD,
    S_VA_RD,
    S_VB_RD,
    S_VC_RD,
    S_DIFF,
    S_MUL,
    S_ACC,
    S_TEST,
    S_DIV,
    S_MIN,
    S_NEXT,
    S_DONE
  } mhq_state_e;

  typedef enum logic [3:0] {
    OPA_ABX, OPA_ABY, OPA_ABZ, OPA_APX, OPA_APY,
    OPA_NX_LO, OPA_NX_HI, OPA_NY_LO, OPA_NY_HI
  } mhq_opa_e;

  typedef enum logic [2:0] {
    OPB_ACX, OPB_ACY, OPB_ACZ, OPB_APX, OPB_APY
  } mhq_opb_e;

  typedef enum logic [2:0] {
    DST_NONE, DST_D, DST_U, DST_V, DST_NX, DST_NY, DST_NUM
  } mhq_dst_e;

  typedef struct packed {
    mhq_opa_e opa;
    mhq_opb_e opb;
    logic     sub;
    logic     first;
    logic     shift;
    mhq_dst_e dst;
  } mhq_step_t;

  // Fourteen signed products, accumulated in pairs or fours into the cross terms.
  function automatic mhq_step_t mhq_step(input logic [StepW-1:0] idx);
    mhq_step_t s;
    s = '{opa: OPA_ABX, opb: OPB_ACY, sub: 1'b0, first: 1'b1, shift: 1'b0, dst: DST_NONE};
    case (idx)
      4'd0:  s = '{OPA_ABX,   OPB_ACY, 1'b0, 1'b1, 1'b0, DST_NONE};
      4'd1:  s = '{OPA_ABY,   OPB_ACX, 1'b1, 1'b0, 1'b0, DST_D};
      4'd2:  s = '{OPA_ABX,   OPB_APY, 1'b0, 1'b1, 1'b0, DST_NONE};
      4'd3:  s = '{OPA_ABY,   OPB_APX, 1'b1, 1'b0, 1'b0, DST_U};
      4'd4:  s = '{OPA_APX,   OPB_ACY, 1'b0, 1'b1, 1'b0, DST_NONE};
      4'd5:  s = '{OPA_APY,   OPB_ACX, 1'b1, 1'b0, 1'b0, DST_V};
      4'd6:  s = '{OPA_ABY,   OPB_ACZ, 1'b0, 1'b1, 1'b0, DST_NONE};
      4'd7:  s = '{OPA_ABZ,   OPB_ACY, 1'b1, 1'b0, 1'b0, DST_NX};
      4'd8:  s = '{OPA_ABZ,   OPB_ACX, 1'b0, 1'b1, 1'b0, DST_NONE};
      4'd9:  s = '{OPA_ABX,   OPB_ACZ, 1'b1, 1'b0, 1'b0, DST_NY};
      4'd10: s = '{OPA_NX_LO, OPB_APX, 1'b0, 1'b1, 1'b0, DST_NONE};
      4'd11: s = '{OPA_NX_HI, OPB_APX, 1'b0, 1'b0, 1'b1, DST_NONE};
      4'd12: s = '{OPA_NY_LO, OPB_APY, 1'b0, 1'b0, 1'b0, DST_NONE};
      4'd13: s = '{OPA_NY_HI, OPB_APY, 1'b0, 1'b0, 1'b1, DST_NUM};
      default: s = '{OPA_ABX, OPB_ACY, 1'b0, 1'b1, 1'b0, DST_NONE};
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/mesh_height_query_top.sv =====
// Mesh height query: vertex and face tables in synchronous memories and a face sequencer.
// Shared multiplier for the cross products, bit-serial divider for the plane height.
// Depends on mhq_pkg.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-------------------------
//   in      | in        | in_valid_i / in_stall_o  | mhq_in_t  in_data_i
//   out     | out       | out_valid_o / out_stall_i| mhq_out_t out_data_o
//   cfg     | in        | cfg_valid_i / cfg_ready_o| faces_in_use, cfg_data_i
//
// Vertex and face writes are taken while the sequencer is idle. After a query is accepted the
// sequencer visits each face in use: it reads the face, checks its corners and reads them, skips
// a face with a corner off the table, a face of zero area or one that misses the point, and for
// a covering face runs fourteen products on the one 34x34 multiplier, each in S_MUL then S_ACC,
// then the radix-2 divider. When all faces are done, S_DONE loads the result register.
// Reset clears control state only; the tables hold nothing defined until written.
// A finished result waits in the output register; while it stalls, the next query waits in S_DONE.
module mesh_height_query_top #(
  parameter int unsigned VERTEX_DEPTH = 1024,
  parameter int unsigned FACE_DEPTH   = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  mhq_pkg::mhq_in_t    in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output mhq_pkg::mhq_out_t   out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [10:0]         cfg_data_i
);
  import mhq_pkg::*;

  localparam int unsigned VA  = $clog2(VERTEX_DEPTH);
  localparam int unsigned FA  = (FACE_DEPTH > 1) ? $clog2(FACE_DEPTH) : 1;
  localparam int unsigned FCW = $clog2(FACE_DEPTH + 1);

  // tables
  logic [VertW-1:0] vert_mem [VERTEX_DEPTH];
  logic [FaceW-1:0] face_mem [FACE_DEPTH];
  logic [VertW-1:0] vert_rd_q;
  logic [FaceW-1:0] face_rd_q;
  logic             vert_rd_en, face_rd_en;
  logic [VA-1:0]    vert_addr;

  mhq_state_e state_q, state_d;
  logic [CfgW-1:0] faces_in_use_q;
  logic [FCW-1:0]  face_idx_q, n_q, n_cfg;
  logic            in_accept, is_query, wr_vert, wr_face;

  logic signed [CoordW-1:0] px_q, py_q, ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  logic signed [DiffW-1:0]  abx_q, aby_q, abz_q, acx_q, acy_q, acz_q, apx_q, apy_q;
  logic signed [CoordW-1:0] cx, cy, cz;

  logic [StepW-1:0]         step_q;
  mhq_step_t                cur;
  logic signed [MulW-1:0]   op_a, op_b;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AccW-1:0]   acc_q, acc_d, term, addend;
  logic signed [CrossW-1:0] d_q, u_q, v_q, nx_q, ny_q;

  logic signed [CrossW-1:0] su, sv, sd;
  logic signed [CrossW:0]   uv_sum;
  logic                     covers;

  logic signed [AccW-1:0]   num_mag;
  logic [CrossW-1:0]        d_mag;
  logic [DivW-1:0]          dq_q;
  logic [CrossW-1:0]        rem_q, ud_q;
  logic [CrossW:0]          rem_sh, rem_nx;
  logic                     rem_ge, qneg_q;
  logic [DivCntW-1:0]       div_cnt_q;

  logic signed [AccW-1:0]   q_s, z_val, best_q;
  logic                     hit_q, in_range;
  logic                     out_valid_q;
  mhq_out_t                 out_q;
  logic [IndexW-1:0]        fa, fb, fc;
  logic                     corners_ok;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != S_IDLE);
  assign is_query    = in_data_i.func == FUNC_QUERY;
  assign wr_vert     = in_accept && (in_data_i.func == FUNC_VERTEX)
                       && (32'(in_data_i.slot) < VERTEX_DEPTH);
  assign wr_face     = in_accept && (in_data_i.func == FUNC_FACE)
                       && (32'(in_data_i.slot) < FACE_DEPTH);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign n_cfg = (32'(faces_in_use_q) > FACE_DEPTH) ? FCW'(FACE_DEPTH) : FCW'(faces_in_use_q);

  assign fa = face_rd_q[IndexW-1:0];
  assign fb = face_rd_q[2*IndexW-1:IndexW];
  assign fc = face_rd_q[3*IndexW-1:2*IndexW];
  assign corners_ok = (32'(fa) < VERTEX_DEPTH) && (32'(fb) < VERTEX_DEPTH)
                      && (32'(fc) < VERTEX_DEPTH);

  assign cx = vert_rd_q[CoordW-1:0];
  assign cy = vert_rd_q[2*CoordW-1:CoordW];
  assign cz = vert_rd_q[3*CoordW-1:2*CoordW];

  // product step
  assign cur = mhq_step(step_q);

  always_comb begin
    case (cur.opa)
      OPA_ABX:   op_a = {abx_q[DiffW-1], abx_q};
      OPA_ABY:   op_a = {aby_q[DiffW-1], aby_q};
      OPA_ABZ:   op_a = {abz_q[DiffW-1], abz_q};
      OPA_APX:   op_a = {apx_q[DiffW-1], apx_q};
      OPA_APY:   op_a = {apy_q[DiffW-1], apy_q};
      OPA_NX_LO: op_a = {1'b0, nx_q[HiShift-1:0]};
      OPA_NX_HI: op_a = nx_q[CrossW-1:HiShift];
      OPA_NY_LO: op_a = {1'b0, ny_q[HiShift-1:0]};
      OPA_NY_HI: op_a = ny_q[CrossW-1:HiShift];
      default:   op_a = '0;
    endcase
    case (cur.opb)
      OPB_ACX: op_b = {acx_q[DiffW-1], acx_q};
      OPB_ACY: op_b = {acy_q[DiffW-1], acy_q};
      OPB_ACZ: op_b = {acz_q[DiffW-1], acz_q};
      OPB_APX: op_b = {apx_q[DiffW-1], apx_q};
      OPB_APY: op_b = {apy_q[DiffW-1], apy_q};
      default: op_b = '0;
    endcase
  end

  always_comb begin
    term   = {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
    if (cur.shift) begin
      term = term <<< HiShift;
    end
    addend = cur.sub ? -term : term;
    acc_d  = cur.first ? addend : acc_q + addend;
  end

  // inside test with edges included, signs folded by the sign of the area
  always_comb begin
    su     = d_q[CrossW-1] ? -u_q : u_q;
    sv     = d_q[CrossW-1] ? -v_q : v_q;
    sd     = d_q[CrossW-1] ? -d_q : d_q;
    uv_sum = {su[CrossW-1], su} + {sv[CrossW-1], sv};
    covers = !su[CrossW-1] && !sv[CrossW-1] && !($signed({sd[CrossW-1], sd}) < uv_sum);
  end

  always_comb begin
    num_mag = acc_d[AccW-1] ? -acc_d : acc_d;
    d_mag   = d_q[CrossW-1] ? -d_q : d_q;
    rem_sh  = {rem_q, dq_q[DivW-1]};
    rem_ge  = rem_sh >= {1'b0, ud_q};
    rem_nx  = rem_ge ? rem_sh - {1'b0, ud_q} : rem_sh;
    q_s     = qneg_q ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
    z_val   = {{(AccW-CoordW){az_q[CoordW-1]}}, az_q} - q_s;
    in_range = (&best_q[AccW-1:CoordW-1]) || !(|best_q[AccW-1:CoordW-1]);
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept && is_query) begin
          state_d = (n_cfg == '0) ? S_DONE : S_FACE_RD;
        end
      end
      S_FACE_RD: state_d = S_VA_RD;
      S_VA_RD:   state_d = corners_ok ? S_VB_RD : S_NEXT;
      S_VB_RD:   state_d = S_VC_RD;
      S_VC_RD:   state_d = S_DIFF;
      S_DIFF:    state_d = S_MUL;
      S_MUL:     state_d = S_ACC;
      S_ACC: begin
        case (cur.dst)
          DST_D:   state_d = (acc_d == '0) ? S_NEXT : S_MUL;
          DST_V:   state_d = S_TEST;
          DST_NUM: state_d = S_DIV;
          default: state_d = S_MUL;
        endcase
      end
      S_TEST: state_d = covers ? S_MUL : S_NEXT;
      S_DIV:  state_d = (div_cnt_q == DivCntW'(1)) ? S_MIN : S_DIV;
      S_MIN:  state_d = S_NEXT;
      S_NEXT: state_d = (face_idx_q + FCW'(1) == n_q) ? S_DONE : S_FACE_RD;
      S_DONE: state_d = (!out_valid_q || !out_stall_i) ? S_IDLE : S_DONE;
      default: state_d = S_IDLE;
    endcase
  end

  // memory read controls
  always_comb begin
    face_rd_en = 1'b0;
    vert_rd_en = 1'b0;
    vert_addr  = VA'(fa);
    case (state_q)
      S_FACE_RD: face_rd_en = 1'b1;
      S_VA_RD: begin
        vert_rd_en = corners_ok;
        vert_addr  = VA'(fa);
      end
      S_VB_RD: begin
        vert_rd_en = 1'b1;
        vert_addr  = VA'(fb);
      end
      S_VC_RD: begin
        vert_rd_en = 1'b1;
        vert_addr  = VA'(fc);
      end
      default: vert_rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_vert) begin
      vert_mem[VA'(in_data_i.slot)] <= {in_data_i.coord_z, in_data_i.coord_y, in_data_i.coord_x};
    end
    if (vert_rd_en) begin
      vert_rd_q <= vert_mem[vert_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_face) begin
      face_mem[FA'(in_data_i.slot)] <= {in_data_i.corner_c, in_data_i.corner_b,
                                        in_data_i.corner_a};
    end
    if (face_rd_en) begin
      face_rd_q <= face_mem[face_idx_q[FA-1:0]];
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      faces_in_use_q <= '0;
      out_valid_q    <= 1'b0;
      hit_q          <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        faces_in_use_q <= cfg_data_i;
      end
      if (state_q == S_IDLE && in_accept && is_query) begin
        hit_q <= 1'b0;
      end else if (state_q == S_MIN) begin
        hit_q <= 1'b1;
      end
      if (state_q == S_DONE && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_accept && is_query) begin
          px_q       <= in_data_i.coord_x;
          py_q       <= in_data_i.coord_y;
          face_idx_q <= '0;
          n_q        <= n_cfg;
        end
      end
      S_VB_RD: begin
        ax_q <= cx;
        ay_q <= cy;
        az_q <= cz;
      end
      S_VC_RD: begin
        bx_q <= cx;
        by_q <= cy;
        bz_q <= cz;
      end
      S_DIFF: begin
        abx_q  <= DiffW'(bx_q) - DiffW'(ax_q);
        aby_q  <= DiffW'(by_q) - DiffW'(ay_q);
        abz_q  <= DiffW'(bz_q) - DiffW'(az_q);
        acx_q  <= DiffW'(cx) - DiffW'(ax_q);
        acy_q  <= DiffW'(cy) - DiffW'(ay_q);
        acz_q  <= DiffW'(cz) - DiffW'(az_q);
        apx_q  <= DiffW'(px_q) - DiffW'(ax_q);
        apy_q  <= DiffW'(py_q) - DiffW'(ay_q);
        step_q <= '0;
      end
      S_MUL: prod_q <= op_a * op_b;
      S_ACC: begin
        acc_q  <= acc_d;
        step_q <= step_q + StepW'(1);
        case (cur.dst)
          DST_D:  d_q  <= acc_d[CrossW-1:0];
          DST_U:  u_q  <= acc_d[CrossW-1:0];
          DST_V:  v_q  <= acc_d[CrossW-1:0];
          DST_NX: nx_q <= acc_d[CrossW-1:0];
          DST_NY: ny_q <= acc_d[CrossW-1:0];
          DST_NUM: begin
            // load the divider with magnitudes, keep the quotient sign
            dq_q      <= num_mag[DivW-1:0];
            ud_q      <= d_mag;
            rem_q     <= '0;
            qneg_q    <= acc_d[AccW-1] ^ d_q[CrossW-1];
            div_cnt_q <= DivCntW'(DivW);
          end
          default: ;
        endcase
      end
      S_DIV: begin
        rem_q     <= rem_nx[CrossW-1:0];
        dq_q      <= {dq_q[DivW-2:0], rem_ge};
        div_cnt_q <= div_cnt_q - DivCntW'(1);
      end
      S_MIN: begin
        if (!hit_q || (z_val < best_q)) begin
          best_q <= z_val;
        end
      end
      S_NEXT: face_idx_q <= face_idx_q + FCW'(1);
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_q.hit <= hit_q;
          if (!hit_q) begin
            out_q.altitude <= 32'sh7FFF_FFFF;
          end else if (in_range) begin
            out_q.altitude <= best_q[CoordW-1:0];
          end else if (best_q[AccW-1]) begin
            out_q.altitude <= 32'sh8000_0000;
          end else begin
            out_q.altitude <= 32'sh7FFF_FFFF;
          end
        end
      end
      default: acc_q <= acc_q;
    endcase
  end

  // checks
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < ud_q))
    else $error("divider remainder not below divisor");

  a_face_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FACE_RD) |-> (face_idx_q < n_q))
    else $error("face index beyond faces in use");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside the done state");

  a_miss_altitude: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.hit) |-> (out_q.altitude == 32'sh7FFF_FFFF))
    else $error("miss result carries a height");

endmodule

// ===== tb/sv/mesh_height_query_top_tb.sv =====
// Self-checking bench for mesh_height_query_top: a table of directed transfers, then random
// vertex, face and query transfers, each query checked against an exact 128-bit height model.
// Depends on mhq_pkg and the RTL of mesh_height_query_top.
`timescale 1ns / 100ps

module mesh_height_query_top_tb;
  import mhq_pkg::*;

  localparam int unsigned NumVert = 1024;
  localparam int unsigned NumFace = 1024;
  localparam int unsigned FillVerts = 70;
  localparam int unsigned FillFaces = 64;
  localparam int unsigned StallLimit = 400000;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    mhq_in_t  item;
    logic     known;
    mhq_out_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  mhq_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  mhq_out_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [10:0] cfg_data_i = '0;

  always #6 clk_i = ~clk_i;

  mesh_height_query_top i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o, .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  // Shadow of the mesh, as the block should hold it.
  logic [31:0] vx_mem [NumVert];
  logic [31:0] vy_mem [NumVert];
  logic [31:0] vz_mem [NumVert];
  logic [29:0] face_mem [NumFace];
  bit          vert_set [NumVert];
  logic [10:0] face_count = '0;

  mhq_out_t height_q[$];
  int unsigned fail_cnt = 0;
  int unsigned query_cnt = 0;
  int unsigned hit_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned send_idle_pct = 18;
  int unsigned recv_idle_pct = 68;

  function automatic mhq_out_t lowest_height(logic signed [31:0] qx, logic signed [31:0] qy);
    wide_t ax, ay, az, abx, aby, abz, acx, acy, acz, apx, apy;
    wide_t d, u, v, nx, ny, num, z, best;
    logic [9:0] ia, ib, ic;
    bit found;
    mhq_out_t r;
    found = 0;
    best = 0;
    for (int i = 0; i < face_count && i < NumFace; i++) begin
      {ic, ib, ia} = face_mem[i];
      ax = signed'(vx_mem[ia]); ay = signed'(vy_mem[ia]); az = signed'(vz_mem[ia]);
      abx = signed'(vx_mem[ib]) - ax; aby = signed'(vy_mem[ib]) - ay;
      abz = signed'(vz_mem[ib]) - az;
      acx = signed'(vx_mem[ic]) - ax; acy = signed'(vy_mem[ic]) - ay;
      acz = signed'(vz_mem[ic]) - az;
      d = abx * acy - aby * acx;
      if (d == 0) continue;
      apx = wide_t'(qx) - ax;
      apy = wide_t'(qy) - ay;
      u = abx * apy - aby * apx;
      v = apx * acy - apy * acx;
      if (d < 0) begin
        u = -u; v = -v;
      end
      if (u < 0 || v < 0 || (d < 0 ? -d : d) < u + v) continue;
      nx = aby * acz - abz * acy;
      ny = abz * acx - abx * acz;
      num = nx * apx + ny * apy;
      z = az - num / d;
      if (!found || z < best) best = z;
      found = 1;
    end
    r.hit = found;
    if (!found) r.altitude = 32'sh7FFFFFFF;
    else if (best < -128'sd2147483648) r.altitude = 32'sh80000000;
    else if (best > 128'sd2147483647) r.altitude = 32'sh7FFFFFFF;
    else r.altitude = best[31:0];
    return r;
  endfunction

  // Queue one expected result behind the others.
  function automatic void append_height(mhq_out_t h);
    height_q.insert(height_q.size(), h);
  endfunction

  // Update the shadow and queue the expected height for one accepted transfer.
  function automatic void track_transfer(mhq_in_t t);
    case (t.func)
      FUNC_VERTEX: begin
        vx_mem[t.slot] = t.coord_x; vy_mem[t.slot] = t.coord_y; vz_mem[t.slot] = t.coord_z;
        vert_set[t.slot] = 1;
      end
      FUNC_FACE: face_mem[t.slot] = {t.corner_c, t.corner_b, t.corner_a};
      FUNC_QUERY: append_height(lowest_height(t.coord_x, t.coord_y));
      default: ;
    endcase
  endfunction

  // Valid stays high after a transfer; the next idle cycle or drain() drops it.
  task automatic send(mhq_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= t;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_transfer(t);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (height_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_faces(logic [10:0] n);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= n;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    face_count = n;
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: random stall, check each result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        idle_cnt <= 0;
        if (height_q.size() == 0) begin
          $error("unexpected result altitude=%0d hit=%0b", out_data_o.altitude, out_data_o.hit);
          fail_cnt++;
        end else begin
          mhq_out_t w;
          w = height_q.pop_front();
          query_cnt++;
          if (w.hit) hit_cnt++;
          if (out_data_o.altitude !== w.altitude) begin
            $error("altitude expected %0d actual %0d", w.altitude, out_data_o.altitude);
            fail_cnt++;
          end
          if (out_data_o.hit !== w.hit) begin
            $error("hit expected %0b actual %0b", w.hit, out_data_o.hit);
            fail_cnt++;
          end
        end
      end else if (in_valid_i && !in_stall_o) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (idle_cnt >= StallLimit) begin
      $display("timeout: nothing transferred for %0d cycles", StallLimit);
      $display("FAIL");
      $finish;
    end
  end

  function automatic mhq_in_t mk(mhq_func_e f, int unsigned s, logic [31:0] x, logic [31:0] y,
                                 logic [31:0] z, int unsigned a, int unsigned b, int unsigned c);
    mhq_in_t t;
    t.func = f; t.slot = IndexW'(s); t.coord_x = x; t.coord_y = y; t.coord_z = z;
    t.corner_a = IndexW'(a); t.corner_b = IndexW'(b); t.corner_c = IndexW'(c);
    return t;
  endfunction

  function automatic int unsigned any_vertex();
    int unsigned k;
    k = $urandom_range(NumVert - 1);
    while (!vert_set[k]) k = $urandom_range(NumVert - 1);
    return k;
  endfunction

  // Coordinates mostly near a small window so queries land inside faces.
  function automatic logic [31:0] rand_coord(int unsigned bias);
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < bias) return $urandom_range(32'h60000) - 32'h30000;
    if (sel < bias + 5) return ($urandom_range(1)) ? 32'h7FFFFFFF : 32'h80000000;
    return $urandom();
  endfunction

  dir_row_t dir_tab[$];

  function automatic void add_row(mhq_in_t item, logic known, mhq_out_t want);
    dir_row_t r;
    r.item = item;
    r.known = known;
    r.want = want;
    dir_tab.insert(dir_tab.size(), r);
  endfunction

  initial begin
    mhq_in_t t;
    int unsigned nf;
    logic [31:0] big;
    logic [31:0] neg;
    big = 32'h7FFFFFFF;
    neg = 32'h80000000;
    // Queries before any face is in use: no covering face.
    add_row(mk(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0), 1'b1, '{32'sh7FFFFFFF, 1'b0});
    add_row(mk(FUNC_QUERY, 0, big, neg, 0, 0, 0, 0), 1'b1, '{32'sh7FFFFFFF, 1'b0});
    // Flat triangle at z = 5.0, a steep one, an extreme one, a zero-area one.
    add_row(mk(FUNC_VERTEX, 0, 0, 0, 32'h50000, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_VERTEX, 1, 32'h100000, 0, 32'h50000, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_VERTEX, 2, 0, 32'h100000, 32'h50000, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_VERTEX, 3, neg, neg, big, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_VERTEX, 4, big, neg, neg, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_VERTEX, 1023, neg, big, neg, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_VERTEX, 5, 32'h200000, 32'h200000, neg, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_FACE, 0, 0, 0, 0, 0, 1, 2), 1'b0, '0);
    add_row(mk(FUNC_FACE, 1, 0, 0, 0, 3, 4, 1023), 1'b0, '0);
    add_row(mk(FUNC_FACE, 2, 0, 0, 0, 0, 5, 5), 1'b0, '0);
    add_row(mk(FUNC_FACE, 3, 0, 0, 0, 1, 0, 5), 1'b0, '0);
    add_row(mk(FUNC_FACE, 1023, 0, 0, 0, 1023, 1023, 1023), 1'b0, '0);
    add_row(mk(mhq_func_e'(2'd3), 1023, big, big, big, 1023, 1023, 1023), 1'b0, '0);
    add_row(mk(FUNC_QUERY, 0, 32'h40000, 32'h40000, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_QUERY, 0, 0, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_QUERY, 0, 32'h100000, 0, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_QUERY, 0, 32'h80000, 32'h80000, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_QUERY, 0, big, big, 0, 0, 0, 0), 1'b0, '0);
    add_row(mk(FUNC_QUERY, 0, neg, 0, 0, 0, 0, 0), 1'b0, '0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < dir_tab.size(); i++) begin
      if (i == 9) set_faces(11'd4);
      if (dir_tab[i].known) begin
        drain();
        send(dir_tab[i].item);
        // Replace the computed expectation by the one typed in the table.
        height_q[height_q.size() - 1] = dir_tab[i].want;
      end else send(dir_tab[i].item);
    end
    set_faces(11'(FillFaces));
    for (int k = 6; k < FillVerts; k++)
      if (!vert_set[k]) send(mk(FUNC_VERTEX, k, rand_coord(90), rand_coord(90),
                                rand_coord(80), 0, 0, 0));
    for (int k = 4; k < FillFaces; k++)
      send(mk(FUNC_FACE, k, 0, 0, 0, any_vertex(), any_vertex(), any_vertex()));
    send(mk(FUNC_QUERY, 0, 32'h10000, 32'h10000, 0, 0, 0, 0));
    set_faces(11'(FillFaces - 1));
    send(mk(FUNC_QUERY, 0, 32'h20000, 32'h8000, 0, 0, 0, 0));

    // Random part: three idling phases, small face counts, well-formed meshes mostly.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 18 : (ph == 1) ? 68 : 0;
      recv_idle_pct = (ph == 0) ? 68 : (ph == 1) ? 18 : 0;
      for (int n = 0; n < 130; n++) begin
        int unsigned sel;
        if (n % 45 == 0) begin
          nf = ($urandom_range(9) == 0) ? $urandom_range(FillFaces) : $urandom_range(12);
          set_faces(nf[10:0]);
        end
        sel = $urandom_range(99);
        if (sel < 30) t = mk(FUNC_VERTEX, $urandom_range(NumVert - 1), rand_coord(85),
                             rand_coord(85), rand_coord(75), 0, 0, 0);
        else if (sel < 45) t = mk(FUNC_FACE, $urandom_range(15), $urandom(), $urandom(),
                                  $urandom(), any_vertex(), any_vertex(), any_vertex());
        else if (sel < 48) t = mk(mhq_func_e'(2'd3), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom(), $urandom(), $urandom());
        else t = mk(FUNC_QUERY, $urandom(), rand_coord(85), rand_coord(85), $urandom(),
                    $urandom(), $urandom(), $urandom());
        if (t.func == FUNC_VERTEX) vert_set[t.slot] = 1;
        send(t);
      end
    end

    drain();
    $display("ran %0d queries (%0d with a covering face) over directed and random meshes",
             query_cnt, hit_cnt);
    $display("face counts from 0 to %0d, three idling mixes on both channels", FillFaces);
    if (fail_cnt == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
